>>> rtl/core/tlbpw_pkg.sv
package tlbpw_pkg;

    localparam int OFFSET_WIDTH = 12;
    localparam int DIR_WIDTH = 6;
    localparam int TABLE_WIDTH = 10;
    localparam int TLB_DEPTH = 64;
    localparam int FRAME_WIDTH = 16;

    localparam int KIND_WIDTH = 2;
    localparam int VA_WIDTH = 28;
    localparam int PA_WIDTH = 28;
    localparam int FRAME_FIELD_WIDTH = 16;
    localparam int STATUS_WIDTH = 2;

    localparam int VPN_BITS = DIR_WIDTH + TABLE_WIDTH;
    localparam int ENTRY_COUNT = 1 << VPN_BITS;
    localparam int DIR_COUNT = 1 << DIR_WIDTH;
    localparam int SLOT_WIDTH = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
    localparam int ENTRY_WIDTH = FRAME_WIDTH + 1;
    localparam int TLB_WIDTH = VPN_BITS + FRAME_WIDTH;

    localparam logic [KIND_WIDTH-1:0] KIND_TRANSLATE = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_MAP = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_UNMAP = 2'd2;

    localparam logic [STATUS_WIDTH-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_FAULT = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_MAPPED = 2'd2;

    function automatic logic [PA_WIDTH-1:0] make_pa(
        input logic [FRAME_WIDTH-1:0] frame,
        input logic [OFFSET_WIDTH-1:0] offset
    );
        logic [FRAME_WIDTH+OFFSET_WIDTH+PA_WIDTH-1:0] wide;
        wide = {{PA_WIDTH{1'b0}}, frame, offset};
        return wide[PA_WIDTH-1:0];
    endfunction

    function automatic logic [FRAME_WIDTH-1:0] field_to_frame(
        input logic [FRAME_FIELD_WIDTH-1:0] value
    );
        logic [FRAME_FIELD_WIDTH+FRAME_WIDTH-1:0] wide;
        wide = {{FRAME_WIDTH{1'b0}}, value};
        return wide[FRAME_WIDTH-1:0];
    endfunction

    function automatic logic [FRAME_FIELD_WIDTH-1:0] frame_to_field(
        input logic [FRAME_WIDTH-1:0] value
    );
        logic [FRAME_FIELD_WIDTH+FRAME_WIDTH-1:0] wide;
        wide = {{FRAME_FIELD_WIDTH{1'b0}}, value};
        return wide[FRAME_FIELD_WIDTH-1:0];
    endfunction

endpackage

>>> rtl/core/tlbpw_req_if.sv
interface tlbpw_req_if;

    logic                                 valid;
    logic                                 ready;
    logic [tlbpw_pkg::KIND_WIDTH-1:0]        kind;
    logic [tlbpw_pkg::VA_WIDTH-1:0]          virt_addr;
    logic [tlbpw_pkg::FRAME_FIELD_WIDTH-1:0] phys_frame;

    modport source (output valid, output kind, output virt_addr, output phys_frame,
                    input ready);
    modport sink (input valid, input kind, input virt_addr, input phys_frame,
                  output ready);

endinterface

>>> rtl/core/tlbpw_rsp_if.sv
interface tlbpw_rsp_if;

    logic                                    valid;
    logic                                    ready;
    logic [tlbpw_pkg::STATUS_WIDTH-1:0]      status;
    logic [tlbpw_pkg::PA_WIDTH-1:0]          phys_addr;
    logic                                    tlb_hit;
    logic                                    freed_valid;
    logic [tlbpw_pkg::FRAME_FIELD_WIDTH-1:0] freed_frame;

    modport source (output valid, output status, output phys_addr, output tlb_hit,
                    output freed_valid, output freed_frame, input ready);
    modport sink (input valid, input status, input phys_addr, input tlb_hit,
                  input freed_valid, input freed_frame, output ready);

endinterface

>>> rtl/core/tlbpw_ram.sv
module tlbpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/tlb_two_level_page_walk.sv
// On acceptance of a word the TLB and page-entry reads are issued. In the execute state,
// once the output register is free, the registered read data is consumed, any write-back
// is made and the output register is loaded; only then is a new word accepted.
// The result is registered and holds until taken. After reset all 65536 page-entry
// memory entries are swept clear, one entry a cycle, during which no word is accepted.
module tlb_two_level_page_walk (
    input  logic          clk,
    input  logic          rst_n,
    tlbpw_req_if.sink     req,
    tlbpw_rsp_if.source   rsp
);
    import tlbpw_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                       state_reg, state_next;
    logic                       clr_busy_reg, clr_busy_next;
    logic [VPN_BITS-1:0]        clr_addr_reg, clr_addr_next;
    logic                       out_valid_reg, out_valid_next;
    logic [TLB_DEPTH-1:0]       tlb_valid_reg, tlb_valid_next;
    logic [DIR_COUNT-1:0]       dir_present_reg, dir_present_next;

    logic [KIND_WIDTH-1:0]      kind_reg;
    logic [VPN_BITS-1:0]        vpn_reg;
    logic [OFFSET_WIDTH-1:0]    offset_reg;
    logic [SLOT_WIDTH-1:0]      slot_reg;
    logic [FRAME_WIDTH-1:0]     frame_in_reg;

    logic [STATUS_WIDTH-1:0]      status_reg;
    logic [PA_WIDTH-1:0]          phys_addr_reg;
    logic                         tlb_hit_reg;
    logic                         freed_valid_reg;
    logic [FRAME_FIELD_WIDTH-1:0] freed_frame_reg;

    logic [63:0]                va_ext;
    logic [VPN_BITS-1:0]        vpn_in;
    logic [SLOT_WIDTH-1:0]      slot_in;
    logic                       accept;
    logic                       exec_fire;

    logic [ENTRY_WIDTH-1:0]     ent_rd_data;
    logic [TLB_WIDTH-1:0]       tlb_rd_data;
    logic                       ent_present;
    logic [FRAME_WIDTH-1:0]     ent_frame;
    logic [VPN_BITS-1:0]        tlb_page;
    logic [FRAME_WIDTH-1:0]     tlb_frame;
    logic [DIR_WIDTH-1:0]       dir_idx;
    logic                       tlb_match;
    logic                       walk_ok;

    logic                         ent_we;
    logic [ENTRY_WIDTH-1:0]       ent_wdata;
    logic                         tlb_we;
    logic                         tlb_set;
    logic                         tlb_clear;
    logic                         dir_set;
    logic [STATUS_WIDTH-1:0]      status_c;
    logic [PA_WIDTH-1:0]          pa_c;
    logic                         hit_c;
    logic                         fvalid_c;
    logic [FRAME_FIELD_WIDTH-1:0] fframe_c;

    logic                       ram_ent_we;
    logic [VPN_BITS-1:0]        ram_ent_waddr;
    logic [ENTRY_WIDTH-1:0]     ram_ent_wdata;

    assign va_ext = 64'(req.virt_addr);
    assign vpn_in = va_ext[OFFSET_WIDTH +: VPN_BITS];
    assign slot_in = SLOT_WIDTH'(vpn_in % TLB_DEPTH);

    assign req.ready = (state_reg == S_IDLE) && !clr_busy_reg;
    assign accept = req.valid && req.ready;
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);

    assign ent_present = ent_rd_data[FRAME_WIDTH];
    assign ent_frame = ent_rd_data[FRAME_WIDTH-1:0];
    assign tlb_page = tlb_rd_data[TLB_WIDTH-1:FRAME_WIDTH];
    assign tlb_frame = tlb_rd_data[FRAME_WIDTH-1:0];
    assign dir_idx = vpn_reg[VPN_BITS-1:TABLE_WIDTH];
    assign tlb_match = tlb_valid_reg[slot_reg] && (tlb_page == vpn_reg);
    assign walk_ok = dir_present_reg[dir_idx] && ent_present;

    always_comb
    begin
        ent_we = 1'b0;
        ent_wdata = '0;
        tlb_we = 1'b0;
        tlb_set = 1'b0;
        tlb_clear = 1'b0;
        dir_set = 1'b0;
        status_c = STATUS_OK;
        pa_c = '0;
        hit_c = 1'b0;
        fvalid_c = 1'b0;
        fframe_c = '0;
        unique case (kind_reg)
            KIND_TRANSLATE:
            begin
                if (tlb_match)
                begin
                    hit_c = 1'b1;
                    pa_c = make_pa(tlb_frame, offset_reg);
                end
                else if (!walk_ok)
                begin
                    status_c = STATUS_FAULT;
                end
                else
                begin
                    tlb_we = 1'b1;
                    tlb_set = 1'b1;
                    pa_c = make_pa(ent_frame, offset_reg);
                end
            end
            KIND_MAP:
            begin
                dir_set = 1'b1;
                if (ent_present)
                begin
                    status_c = STATUS_MAPPED;
                end
                else
                begin
                    ent_we = 1'b1;
                    ent_wdata = {1'b1, frame_in_reg};
                end
            end
            KIND_UNMAP:
            begin
                if (walk_ok)
                begin
                    fvalid_c = 1'b1;
                    fframe_c = frame_to_field(ent_frame);
                    ent_we = 1'b1;
                    ent_wdata = '0;
                    tlb_clear = tlb_match;
                end
            end
            default:
            begin
                status_c = STATUS_OK;
            end
        endcase
    end

    assign ram_ent_we = clr_busy_reg || (exec_fire && ent_we);
    assign ram_ent_waddr = clr_busy_reg ? clr_addr_reg : vpn_reg;
    assign ram_ent_wdata = clr_busy_reg ? '0 : ent_wdata;

    tlbpw_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (ENTRY_COUNT)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_ent_we),
        .wr_addr (ram_ent_waddr),
        .wr_data (ram_ent_wdata),
        .rd_en   (accept),
        .rd_addr (vpn_in),
        .rd_data (ent_rd_data)
    );

    tlbpw_ram #(
        .WIDTH (TLB_WIDTH),
        .DEPTH (TLB_DEPTH)
    ) u_tlb_ram (
        .clk     (clk),
        .wr_en   (exec_fire && tlb_we),
        .wr_addr (slot_reg),
        .wr_data ({vpn_reg, ent_frame}),
        .rd_en   (accept),
        .rd_addr (slot_in),
        .rd_data (tlb_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        out_valid_next = out_valid_reg;
        tlb_valid_next = tlb_valid_reg;
        dir_present_next = dir_present_reg;

        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + VPN_BITS'(1);
            if (&clr_addr_reg)
            begin
                clr_busy_next = 1'b0;
            end
        end

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = S_IDLE;
                    out_valid_next = 1'b1;
                    if (tlb_set)
                    begin
                        tlb_valid_next[slot_reg] = 1'b1;
                    end
                    if (tlb_clear)
                    begin
                        tlb_valid_next[slot_reg] = 1'b0;
                    end
                    if (dir_set)
                    begin
                        dir_present_next[dir_idx] = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            out_valid_reg <= 1'b0;
            tlb_valid_reg <= '0;
            dir_present_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            tlb_valid_reg <= tlb_valid_next;
            dir_present_reg <= dir_present_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= req.kind;
            vpn_reg <= vpn_in;
            offset_reg <= va_ext[OFFSET_WIDTH-1:0];
            slot_reg <= slot_in;
            frame_in_reg <= field_to_frame(req.phys_frame);
        end
        if (exec_fire)
        begin
            status_reg <= status_c;
            phys_addr_reg <= pa_c;
            tlb_hit_reg <= hit_c;
            freed_valid_reg <= fvalid_c;
            freed_frame_reg <= fframe_c;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.status = status_reg;
    assign rsp.phys_addr = phys_addr_reg;
    assign rsp.tlb_hit = tlb_hit_reg;
    assign rsp.freed_valid = freed_valid_reg;
    assign rsp.freed_frame = freed_frame_reg;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tlbpw_pkg::*;

    localparam logic [KIND_WIDTH-1:0] KIND_UNDEFINED = 2'd3;
    localparam int RANDOM_WORDS = 1200;
    localparam int POOL_SIZE = 32;
    localparam int IDLE_LIMIT = 200000;

    typedef logic [VPN_BITS-1:0] vpn_t;
    typedef logic [FRAME_WIDTH-1:0] frame_t;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]        kind;
        logic [VA_WIDTH-1:0]          virt_addr;
        logic [FRAME_FIELD_WIDTH-1:0] phys_frame;
    } page_op_t;

    typedef struct packed {
        logic [STATUS_WIDTH-1:0]      status;
        logic [PA_WIDTH-1:0]          phys_addr;
        logic                         tlb_hit;
        logic                         freed_valid;
        logic [FRAME_FIELD_WIDTH-1:0] freed_frame;
    } page_result_t;

    logic clk = 1'b0;
    logic rst_n;

    tlbpw_req_if req ();
    tlbpw_rsp_if rsp ();

    tlb_two_level_page_walk uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    bit     dir_mapped [DIR_COUNT];
    bit     page_mapped [ENTRY_COUNT];
    frame_t page_frame [ENTRY_COUNT];
    bit     tlb_live [TLB_DEPTH];
    vpn_t   tlb_vpn [TLB_DEPTH];
    frame_t tlb_pfn [TLB_DEPTH];

    page_op_t     ops_to_send [$];
    page_result_t results_due [$];

    int accepted_words = 0;
    int failures = 0;
    int burst_left = 1;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_clock = 0;
    int idle_cycles = 0;
    int n_translate = 0;
    int n_hit = 0;
    int n_walk = 0;
    int n_fault = 0;
    int n_map = 0;
    int n_remap = 0;
    int n_unmap = 0;
    int n_freed = 0;
    int n_undefined = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic page_result_t walk_page_table(input page_op_t op);
        page_result_t res;
        vpn_t vpn;
        logic [OFFSET_WIDTH-1:0] offset;
        logic [DIR_WIDTH-1:0] dir;
        int slot;
        res = '0;
        vpn = op.virt_addr[OFFSET_WIDTH +: VPN_BITS];
        offset = op.virt_addr[OFFSET_WIDTH-1:0];
        dir = vpn[VPN_BITS-1 -: DIR_WIDTH];
        slot = int'(vpn) % TLB_DEPTH;
        case (op.kind)
            KIND_TRANSLATE:
            begin
                if (tlb_live[slot] && tlb_vpn[slot] == vpn)
                begin
                    res.tlb_hit = 1'b1;
                    res.phys_addr = PA_WIDTH'({tlb_pfn[slot], offset});
                end
                else if (!dir_mapped[dir] || !page_mapped[vpn])
                begin
                    res.status = STATUS_FAULT;
                end
                else
                begin
                    tlb_live[slot] = 1'b1;
                    tlb_vpn[slot] = vpn;
                    tlb_pfn[slot] = page_frame[vpn];
                    res.phys_addr = PA_WIDTH'({page_frame[vpn], offset});
                end
            end
            KIND_MAP:
            begin
                dir_mapped[dir] = 1'b1;
                if (page_mapped[vpn])
                begin
                    res.status = STATUS_MAPPED;
                end
                else
                begin
                    page_mapped[vpn] = 1'b1;
                    page_frame[vpn] = op.phys_frame[FRAME_WIDTH-1:0];
                end
            end
            KIND_UNMAP:
            begin
                if (dir_mapped[dir] && page_mapped[vpn])
                begin
                    res.freed_valid = 1'b1;
                    res.freed_frame = FRAME_FIELD_WIDTH'(page_frame[vpn]);
                    page_mapped[vpn] = 1'b0;
                    page_frame[vpn] = '0;
                    if (tlb_live[slot] && tlb_vpn[slot] == vpn)
                    begin
                        tlb_live[slot] = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endtask

    task automatic add_op(input logic [KIND_WIDTH-1:0] kind, input logic [VA_WIDTH-1:0] va,
                          input logic [FRAME_FIELD_WIDTH-1:0] frame);
        ops_to_send.push_back({kind, va, frame});
    endtask

    // Sender: bursts of words separated by random gaps; a zero gap joins two bursts.
    always @(posedge clk)
    begin
        page_op_t op;
        logic send;
        if (rst_n && (!req.valid || req.ready))
        begin
            send = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (ops_to_send.size() > 0)
            begin
                op = ops_to_send.pop_front();
                send = 1'b1;
                req.kind <= op.kind;
                req.virt_addr <= op.virt_addr;
                req.phys_frame <= op.phys_frame;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            req.valid <= send;
        end
    end

    always @(posedge clk)
    begin
        page_op_t op;
        page_result_t want;
        page_result_t got;
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                op = {req.kind, req.virt_addr, req.phys_frame};
                want = walk_page_table(op);
                results_due.push_back(want);
                accepted_words++;
                case (op.kind)
                    KIND_TRANSLATE:
                    begin
                        n_translate++;
                        if (want.tlb_hit)
                            n_hit++;
                        else if (want.status == STATUS_FAULT)
                            n_fault++;
                        else
                            n_walk++;
                    end
                    KIND_MAP:
                    begin
                        n_map++;
                        if (want.status == STATUS_MAPPED)
                            n_remap++;
                    end
                    KIND_UNMAP:
                    begin
                        n_unmap++;
                        if (want.freed_valid)
                            n_freed++;
                    end
                    default:
                    begin
                        n_undefined++;
                    end
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.status, rsp.phys_addr, rsp.tlb_hit, rsp.freed_valid,
                       rsp.freed_frame};
                if (results_due.size() == 0)
                begin
                    $error("Result word arrived with no request outstanding.");
                    failures++;
                end
                else
                begin
                    want = results_due.pop_front();
                    compare_field("status", 32'(want.status), 32'(got.status));
                    compare_field("phys_addr", 32'(want.phys_addr), 32'(got.phys_addr));
                    compare_field("tlb_hit", 32'(want.tlb_hit), 32'(got.tlb_hit));
                    compare_field("freed_valid", 32'(want.freed_valid),
                                  32'(got.freed_valid));
                    compare_field("freed_frame", 32'(want.freed_frame),
                                  32'(got.freed_frame));
                end
            end
            if (stall_clock % 150 == 0)
                stall_mode = $urandom_range(3);
            case (stall_mode)
                0: rsp.ready <= 1'b1;
                1: rsp.ready <= 1'($urandom_range(1));
                2: rsp.ready <= (stall_clock % 4 == 0);
                default: rsp.ready <= (stall_clock % 32 >= 8);
            endcase
            stall_clock++;
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles without a transfer.", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int total;
        int pick;
        vpn_t pool [POOL_SIZE];
        logic [DIR_WIDTH-1:0] dir_choices [4];
        logic [SLOT_WIDTH-1:0] slot_choices [3];
        logic [TABLE_WIDTH-1:0] tbl;
        vpn_t vpn;
        logic [KIND_WIDTH-1:0] kind;

        rst_n = 1'b0;
        req.valid = 1'b0;
        req.kind = KIND_TRANSLATE;
        req.virt_addr = '0;
        req.phys_frame = '0;
        rsp.ready = 1'b0;

        add_op(KIND_TRANSLATE, 28'h0000000, 16'h0000);
        add_op(KIND_UNMAP, 28'h0000123, 16'h0000);
        add_op(KIND_MAP, 28'h0000000, 16'hFFFF);
        add_op(KIND_MAP, 28'h0000FFF, 16'h1234);
        add_op(KIND_TRANSLATE, 28'h0000FFF, 16'h0000);
        add_op(KIND_TRANSLATE, 28'h0000000, 16'h0000);
        add_op(KIND_TRANSLATE, 28'h0001ABC, 16'h0000);
        add_op(KIND_MAP, 28'hFFFF000, 16'h0000);
        add_op(KIND_TRANSLATE, 28'hFFFFFFF, 16'h0000);
        add_op(KIND_TRANSLATE, 28'hFFFFFFF, 16'h0000);
        add_op(KIND_MAP, 28'h0040000, 16'hA5A5);
        add_op(KIND_TRANSLATE, 28'h0040555, 16'h0000);
        add_op(KIND_TRANSLATE, 28'h0000001, 16'h0000);
        add_op(KIND_UNMAP, 28'h0040000, 16'h0000);
        add_op(KIND_TRANSLATE, 28'h0000002, 16'h0000);
        add_op(KIND_UNMAP, 28'h0000000, 16'h0000);
        add_op(KIND_TRANSLATE, 28'h0000000, 16'h0000);
        add_op(KIND_UNMAP, 28'h0000000, 16'h0000);
        add_op(KIND_UNDEFINED, 28'hFFFFFFF, 16'hFFFF);
        add_op(KIND_UNDEFINED, 28'h0000000, 16'h0000);
        add_op(KIND_MAP, 28'h0000000, 16'h5A5A);
        add_op(KIND_TRANSLATE, 28'h0000ABC, 16'h0000);
        add_op(KIND_UNMAP, 28'h8000000, 16'h0000);

        // A small working set of pages, several of which share a TLB slot.
        foreach (dir_choices[i])
            dir_choices[i] = DIR_WIDTH'($urandom);
        foreach (slot_choices[i])
            slot_choices[i] = SLOT_WIDTH'($urandom);
        foreach (pool[i])
        begin
            tbl = TABLE_WIDTH'($urandom);
            tbl[SLOT_WIDTH-1:0] = slot_choices[i % 3];
            pool[i] = {dir_choices[i % 4], tbl};
        end

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            pick = $urandom_range(99);
            if ($urandom_range(99) < 85)
                vpn = pool[$urandom_range(POOL_SIZE - 1)];
            else
                vpn = VPN_BITS'($urandom);
            if (pick < 55)
                kind = KIND_TRANSLATE;
            else if (pick < 78)
                kind = KIND_MAP;
            else if (pick < 94)
                kind = KIND_UNMAP;
            else
                kind = KIND_UNDEFINED;
            add_op(kind, {vpn, OFFSET_WIDTH'($urandom)}, FRAME_FIELD_WIDTH'($urandom));
        end
        total = ops_to_send.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_words < total)
            @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d words: %0d translations (%0d TLB hits, %0d walks, %0d faults),",
                 total, n_translate, n_hit, n_walk, n_fault);
        $display("%0d maps (%0d onto a mapped page), %0d unmaps (%0d freed), %0d undefined.",
                 n_map, n_remap, n_unmap, n_freed, n_undefined);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/core/tlbpw_pkg.sv
rtl/core/tlbpw_req_if.sv
rtl/core/tlbpw_rsp_if.sv
rtl/core/tlbpw_ram.sv
rtl/core/tlb_two_level_page_walk.sv
bench/testbench.sv
